FILE: rtl/bit_run_length_encoder_assert.svh
// Assertion macros shared by the encoder RTL.
`ifndef BIT_RUN_LENGTH_ENCODER_ASSERT_SVH
`define BIT_RUN_LENGTH_ENCODER_ASSERT_SVH

// Same-cycle implication, sampled on clk and idle while rst is high.
`define BRLE_ASSERT_NOW(label, cond, conseq, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (conseq)) \
    else $error(msg);

// Next-cycle implication, sampled on clk and idle while rst is high.
`define BRLE_ASSERT_NEXT(label, cond, conseq, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (conseq)) \
    else $error(msg);

`endif

FILE: rtl/brle_pkg.sv
// Types and constants shared by the bit run-length encoder modules.
package brle_pkg;

  localparam int BYTE_W = 8;
  localparam int CNT_W  = 7;
  localparam int IDX_W  = 3;

  localparam logic [CNT_W-1:0] RUN_MAX = 7'd127;
  localparam logic [IDX_W-1:0] IDX_TOP = 3'd7;

  typedef enum logic {
    OP_DATA  = 1'b0,
    OP_FLUSH = 1'b1
  } op_e_t;

  typedef struct packed {
    op_e_t             op;
    logic [BYTE_W-1:0] data;
  } entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

endpackage

FILE: rtl/brle_in_if.sv
// Input channel: one data byte or an end-of-stream marker per transfer.
interface brle_in_if;
  logic                       valid;
  logic                       ready;
  logic                       kind;
  logic [brle_pkg::BYTE_W-1:0] data_byte;

  modport source (output valid, output kind, output data_byte, input ready);
  modport sink   (input valid, input kind, input data_byte, output ready);
endinterface

FILE: rtl/brle_out_if.sv
// Output channel: one run code per transfer.
interface brle_out_if;
  logic                       valid;
  logic                       ready;
  logic [brle_pkg::BYTE_W-1:0] code_byte;
  logic                       last_of_item;

  modport source (output valid, output code_byte, output last_of_item, input ready);
  modport sink   (input valid, input code_byte, input last_of_item, output ready);
endinterface

FILE: rtl/brle_front.sv
// Front end: accepts input transfers and classifies them into queue entries.
module brle_front (
  input  logic             clk,
  input  logic             rst,
  brle_in_if.sink          items,
  output brle_pkg::entry_t entry,
  output logic             entry_valid,
  input  logic             entry_ready
);
  import brle_pkg::*;

  logic accept;

  assign items.ready = !entry_valid || entry_ready;
  assign accept      = items.valid && items.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid <= 1'b0;
    end else if (accept) begin
      entry_valid <= 1'b1;
    end else if (entry_ready) begin
      entry_valid <= 1'b0;
    end
  end

  // The byte of an end marker carries no meaning, so it is cleared.
  always_ff @(posedge clk) begin
    if (accept) begin
      entry.op   <= items.kind ? OP_FLUSH : OP_DATA;
      entry.data <= items.kind ? '0 : items.data_byte;
    end
  end

endmodule

FILE: rtl/brle_queue.sv
// Short circular queue of classified entries between front and back end.
module brle_queue #(
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  brle_pkg::entry_t push_entry,
  input  logic             push_valid,
  output logic             push_ready,
  output brle_pkg::entry_t head,
  output logic             head_valid,
  input  logic             pop,
  output brle_pkg::qstat_t status
);
  import brle_pkg::*;

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_QW = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0]  PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_QW-1:0] CNT_FULL = CNT_QW'(DEPTH);

  entry_t             store [DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [CNT_QW-1:0]  fill;
  logic               do_push;
  logic               do_pop;

  assign status.full  = (fill == CNT_FULL);
  assign status.empty = (fill == '0);
  assign push_ready   = !status.full;
  assign head_valid   = !status.empty;
  assign head         = store[rd_ptr];
  assign do_push      = push_valid && push_ready;
  assign do_pop       = pop && head_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        fill <= fill + 1'b1;
      end else if (do_pop && !do_push) begin
        fill <= fill - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      store[wr_ptr] <= push_entry;
    end
  end

endmodule

FILE: rtl/brle_back.sv
// Back end: walks each queued byte one bit per cycle while its output is free, and emits run codes.
module brle_back (
  input  logic             clk,
  input  logic             rst,
  input  brle_pkg::entry_t head,
  input  logic             head_valid,
  output logic             pop,
  brle_out_if.source       codes
);
  import brle_pkg::*;

  logic               run_value;
  logic [CNT_W-1:0]   run_count;
  logic [IDX_W-1:0]   bit_idx;

  logic               run_value_next;
  logic [CNT_W-1:0]   run_count_next;
  logic               step;
  logic               emit;
  logic               last;
  logic               item_done;
  logic               bit_now;
  logic [BYTE_W-1:0]  tail_mask;
  logic               tail_differ;
  logic               tail_overflow;

  assign step    = head_valid && (!codes.valid || codes.ready);
  assign pop     = step && item_done;
  assign bit_now = head.data[bit_idx];

  always_comb begin
    run_value_next = run_value;
    run_count_next = run_count;
    emit           = 1'b0;
    last           = 1'b0;
    item_done      = 1'b0;
    tail_mask      = (BYTE_W'(1) << bit_idx) - BYTE_W'(1);
    tail_differ    = 1'b0;
    tail_overflow  = 1'b0;
    case (head.op)
      OP_FLUSH: begin
        emit           = 1'b1;
        last           = 1'b1;
        item_done      = 1'b1;
        run_value_next = 1'b0;
        run_count_next = '0;
      end
      OP_DATA: begin
        if (bit_now == run_value) begin
          if (run_count == RUN_MAX) begin
            emit           = 1'b1;
            run_count_next = CNT_W'(1);
          end else begin
            run_count_next = run_count + 1'b1;
          end
        end else begin
          emit           = (run_count != '0);
          run_value_next = bit_now;
          run_count_next = CNT_W'(1);
        end
        // A later bit of this byte emits if it breaks the run or overflows it.
        tail_differ   = |((head.data ^ {BYTE_W{run_value_next}}) & tail_mask);
        tail_overflow = ({1'b0, run_count_next} + {{(CNT_W + 1 - IDX_W){1'b0}}, bit_idx})
                        > {1'b0, RUN_MAX};
        last          = !tail_differ && !tail_overflow;
        item_done     = (bit_idx == '0);
      end
      default: begin
        item_done = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run_value   <= 1'b0;
      run_count   <= '0;
      bit_idx     <= IDX_TOP;
      codes.valid <= 1'b0;
    end else begin
      if (step) begin
        run_value <= run_value_next;
        run_count <= run_count_next;
        bit_idx   <= item_done ? IDX_TOP : bit_idx - 1'b1;
      end
      if (!codes.valid || codes.ready) begin
        codes.valid <= step && emit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (step && emit) begin
      codes.code_byte    <= {run_value, run_count};
      codes.last_of_item <= last;
    end
  end

endmodule

FILE: rtl/bit_run_length_encoder.sv
// Top level of the bit run-length encoder: front end, entry queue, back end.
//
//   Channel  Direction  Transfer carries
//   items    in         kind (0 data byte, 1 end of stream), data_byte
//   codes    out        code_byte (bit 7 run value, 6..0 length), last_of_item
//
// The back end walks a data byte one bit per cycle when its output is free and
// handles an end marker in a single step. The single-bit walk sets the rate.
// The front end and queue keep taking bytes while the back end works, so a
// byte can be accepted every cycle until the queue fills.
// Reset is synchronous and clears the run state, the queue and the output.
// The back end stalls whenever its output register holds an untaken code.
module bit_run_length_encoder #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic       clk,
  input  logic       rst,
  brle_in_if.sink    items,
  brle_out_if.source codes
);
  import brle_pkg::*;

  `include "bit_run_length_encoder_assert.svh"

  entry_t front_entry;
  logic   front_valid;
  logic   front_ready;
  entry_t head;
  logic   head_valid;
  logic   pop;
  qstat_t qstat;
  logic   zero_len_code;
  logic   front_stalled;

  // The front end registers each transfer and tags it as data or flush.
  brle_front u_front (
    .clk         (clk),
    .rst         (rst),
    .items       (items),
    .entry       (front_entry),
    .entry_valid (front_valid),
    .entry_ready (front_ready)
  );

  // The queue decouples acceptance from the bit-serial work behind it.
  brle_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_entry (front_entry),
    .push_valid (front_valid),
    .push_ready (front_ready),
    .head       (head),
    .head_valid (head_valid),
    .pop        (pop),
    .status     (qstat)
  );

  // The back end owns the run value and count and drives the code output.
  brle_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (head),
    .head_valid (head_valid),
    .pop        (pop),
    .codes      (codes)
  );

  // A valid code whose length field is zero, and a front entry that cannot
  // move on because the queue is full and nothing leaves it.
  assign zero_len_code = codes.valid && (codes.code_byte[CNT_W-1:0] == '0);
  assign front_stalled = front_valid && qstat.full && !pop;

  // Only an end-of-stream flush can produce a zero-length code, and that is
  // always the final code of its item.
  `BRLE_ASSERT_NOW(a_zero_len_is_last, zero_len_code, codes.last_of_item, "zero length not last")

  // The queue cannot report itself full and empty at once.
  `BRLE_ASSERT_NOW(a_queue_status, 1'b1, !(qstat.full && qstat.empty), "queue full and empty")

  // An entry held by the front end while the queue is full is not lost.
  `BRLE_ASSERT_NEXT(a_front_holds, front_stalled, front_valid, "front entry dropped")

endmodule
